// ===== hw/rtl/icr_pkg.sv =====
// package for the integer cube root block
// widths and the stage record shared by the cells and the top level
// no dependencies
`default_nettype none

package icr_pkg;

    localparam int MAG_W   = 64;
    localparam int ROOT_W  = 22;
    localparam int DIGIT_W = 3;
    localparam int PASSES  = 22;
    localparam int X_W     = PASSES * DIGIT_W;
    localparam int SQ_W    = 2 * ROOT_W;
    localparam int REM_W   = 50;
    localparam int TRIAL_W = SQ_W + 3;

    typedef struct packed {
        logic [X_W-1:0]    x;
        logic [REM_W-1:0]  p;
        logic [ROOT_W-1:0] r;
        logic [SQ_W-1:0]   r2;
        logic              neg;
        logic              nz;
    } t_icr_stage;

endpackage

`default_nettype wire

// ===== hw/rtl/icr_if.sv =====
// channel interfaces of the integer cube root block
// depends on icr_pkg
`default_nettype none

interface icr_in_if
    import icr_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [MAG_W-1:0] magnitude;
    logic             negative;

    modport source (output valid, output magnitude, output negative, input ready);
    modport sink   (input valid, input magnitude, input negative, output ready);
endinterface

interface icr_out_if
    import icr_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [ROOT_W-1:0] root;
    logic              root_negative;
    logic              inexact;

    modport source (output valid, output root, output root_negative, output inexact,
                    input ready);
    modport sink   (input valid, input root, input root_negative, input inexact,
                    output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/icr_cell.sv =====
// one cell of the cube root chain: resolves one root bit per transfer
// depends on icr_pkg
`default_nettype none

module icr_cell
    import icr_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire t_icr_stage i_d,
    output logic            o_valid,
    input  wire logic       i_ready,
    output t_icr_stage      o_d
);

    logic                r_valid;
    t_icr_stage          r_d;
    t_icr_stage          n_d;
    logic [REM_W-1:0]    p_in;
    logic [ROOT_W-1:0]   r_sh;
    logic [SQ_W-1:0]     r2_sh;
    logic [SQ_W:0]       sum;
    logic [TRIAL_W-1:0]  trial;
    logic [REM_W-1:0]    trial_x;
    logic                take;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        p_in    = {i_d.p[REM_W-DIGIT_W-1:0], i_d.x[X_W-1 -: DIGIT_W]};
        r_sh    = {i_d.r[ROOT_W-2:0], 1'b0};
        r2_sh   = {i_d.r2[SQ_W-3:0], 2'b00};
        sum     = {1'b0, r2_sh} + {{(SQ_W+1-ROOT_W){1'b0}}, r_sh};
        trial   = {1'b0, sum, 1'b0} + {2'b00, sum} + {{(TRIAL_W-1){1'b0}}, 1'b1};
        trial_x = {{(REM_W-TRIAL_W){1'b0}}, trial};
        take    = p_in >= trial_x;

        n_d     = i_d;
        n_d.x   = {i_d.x[X_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
        n_d.p   = take ? (p_in - trial_x) : p_in;
        n_d.r   = {r_sh[ROOT_W-1:1], take};
        n_d.r2  = take ? (r2_sh + {{(SQ_W-ROOT_W-1){1'b0}}, r_sh, 1'b0}
                          + {{(SQ_W-1){1'b0}}, 1'b1}) : r2_sh;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_d <= n_d;
        end
    end

    assign o_valid = r_valid;
    assign o_d     = r_d;

endmodule

`default_nettype wire

// ===== hw/rtl/integer_cube_root.sv =====
// Integer cube root of a 64-bit magnitude with sign, built as a chain of 22 cells that each
// take in three operand bits and settle one root bit by a trial subtraction. An operand may
// be transferred in every cycle while the chain has room; its result passes cell by cell, and
// a stalled output holds back only the cells behind it while bubbles ahead still fill. A zero
// operand gives a zero, positive, exact root; inexact flags a nonzero final remainder.
// depends on icr_pkg, icr_if and icr_cell
`default_nettype none

module integer_cube_root
    import icr_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    icr_in_if.sink    i_in,
    icr_out_if.source o_out
);

    t_icr_stage       stg_d     [PASSES+1];
    logic [PASSES:0]  stg_valid;
    logic [PASSES:0]  stg_ready;

    always_comb begin
        stg_d[0]     = '0;
        stg_d[0].x   = {{(X_W-MAG_W){1'b0}}, i_in.magnitude};
        stg_d[0].neg = i_in.negative;
        stg_d[0].nz  = |i_in.magnitude;
    end

    assign stg_valid[0] = i_in.valid;
    assign i_in.ready   = stg_ready[0];

    for (genvar k = 0; k < PASSES; k++) begin : g_cell
        icr_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (stg_valid[k]),
            .o_ready (stg_ready[k]),
            .i_d     (stg_d[k]),
            .o_valid (stg_valid[k+1]),
            .i_ready (stg_ready[k+1]),
            .o_d     (stg_d[k+1])
        );
    end

    assign stg_ready[PASSES]   = o_out.ready;
    assign o_out.valid         = stg_valid[PASSES];
    assign o_out.root          = stg_d[PASSES].r;
    assign o_out.root_negative = stg_d[PASSES].neg && stg_d[PASSES].nz;
    assign o_out.inexact       = |stg_d[PASSES].p;

`ifndef SYNTH
    a_root_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.root <= ROOT_W'(2642245)))
        else $error("root beyond range");

    a_sign_nonzero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.root_negative) |-> (o_out.root != '0))
        else $error("negative sign with zero root");

    a_zero_exact : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.root == '0) && !o_out.inexact) |-> !o_out.root_negative)
        else $error("zero operand carries a sign");

    a_ready_empty : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out.valid |-> i_in.ready)
        else $error("input stalled with empty output");
`endif

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
// self-checking testbench for integer_cube_root: directed and random operands, idling on
// both channels, a long output stall and a full drain, results checked field by field
// depends on icr_pkg, icr_if and the integer_cube_root rtl
`default_nettype none

module tb_top
    import icr_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF      = 10;
    localparam int RESET_CYCLES  = 10;
    localparam int LATENCY       = PASSES;
    localparam int HOLD_CYCLES   = 150;
    localparam int RANDOM_ITEMS  = 1500;
    localparam int BLOCK_ITEMS   = 100;
    localparam int MAX_GAP       = 5;
    localparam int ROOT_MAX      = 2642245;
    localparam int TIMEOUT_NS    = 10_000_000;

    typedef struct packed {
        logic [ROOT_W-1:0] root;
        logic              root_negative;
        logic              inexact;
    } t_cube_root_result;

    typedef enum int {
        MAG_FULL  = 0,
        MAG_SHORT = 1,
        MAG_CUBE  = 2,
        MAG_TINY  = 3
    } t_mag_kind;

    logic i_clk;
    logic i_rst_n;

    icr_in_if  in_if ();
    icr_out_if out_if ();

    integer_cube_root u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    t_cube_root_result expected_roots[$];
    t_cube_root_result oldest_root;
    int                failures = 0;
    int                send_gap_max = 0;
    int                take_gap_max = 0;
    bit                hold_request = 1'b0;

    always begin
        i_clk = 1'b0;
        #(CLK_HALF);
        i_clk = 1'b1;
        #(CLK_HALF);
    end

    initial begin
        #(TIMEOUT_NS);
        $display("FAIL");
        $finish;
    end

    // digit-by-digit floor cube root, wide enough that no trial is ever truncated
    function automatic t_cube_root_result cube_root_of(logic [MAG_W-1:0] mag, logic neg);
        logic [127:0]      rem;
        logic [127:0]      r;
        logic [127:0]      r2;
        logic [127:0]      trial;
        logic [127:0]      placed;
        int                k;
        t_cube_root_result res;
        rem = 128'(mag);
        r   = '0;
        r2  = '0;
        for (k = 0; k < PASSES; k++) begin
            r2     = r2 << 2;
            r      = r << 1;
            trial  = 128'd3 * (r2 + r) + 128'd1;
            placed = trial << (MAG_W - 1 - DIGIT_W * k);
            if (rem >= placed) begin
                rem = rem - placed;
                r2  = r2 + (r << 1) + 128'd1;
                r   = r + 128'd1;
            end
        end
        res.root          = r[ROOT_W-1:0];
        res.root_negative = neg && (mag != '0);
        res.inexact       = (rem != '0);
        return res;
    endfunction

    function automatic logic [MAG_W-1:0] draw_magnitude();
        t_mag_kind        kind;
        logic [MAG_W-1:0] m;
        logic [MAG_W-1:0] r;
        int               len;
        kind = t_mag_kind'($urandom_range(0, 3));
        case (kind)
            MAG_FULL: begin
                m = {$urandom, $urandom};
            end
            MAG_SHORT: begin
                len = $urandom_range(1, MAG_W);
                m   = {$urandom, $urandom} >> (MAG_W - len);
            end
            MAG_CUBE: begin
                r = 64'($urandom_range(0, ROOT_MAX));
                m = r * r * r;
                case ($urandom_range(0, 2))
                    0:       m = m - 64'd1;
                    1:       m = m + 64'd1;
                    default: m = m;
                endcase
            end
            default: begin
                m = 64'($urandom_range(0, 100));
            end
        endcase
        return m;
    endfunction

    // one operand transfer; called at a rising edge
    task automatic send_operand(input logic [MAG_W-1:0] mag, input logic neg);
        int gap;
        gap = $urandom_range(0, send_gap_max);
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid     <= 1'b1;
        in_if.magnitude <= mag;
        in_if.negative  <= neg;
        do @(posedge i_clk); while (!in_if.ready);
        expected_roots.push_back(cube_root_of(mag, neg));
    endtask

    task automatic drain_results();
        in_if.valid <= 1'b0;
        do @(posedge i_clk); while (expected_roots.size() != 0);
    endtask

    task automatic test_directed();
        logic [MAG_W-1:0] top_cube;
        top_cube     = 64'(ROOT_MAX) * 64'(ROOT_MAX) * 64'(ROOT_MAX);
        send_gap_max = 0;
        take_gap_max = 0;
        send_operand('0, 1'b0);
        send_operand('0, 1'b1);
        send_operand(64'd1, 1'b0);
        send_operand(64'd1, 1'b1);
        send_operand(64'd7, 1'b0);
        send_operand(64'd8, 1'b1);
        send_operand(64'd9, 1'b0);
        send_operand(64'd26, 1'b0);
        send_operand(64'd27, 1'b1);
        send_operand(64'd28, 1'b0);
        send_operand(64'd999_999, 1'b0);
        send_operand(64'd1_000_000, 1'b1);
        send_operand('1, 1'b0);
        send_operand('1, 1'b1);
        send_operand(top_cube, 1'b0);
        send_operand(top_cube - 64'd1, 1'b1);
        send_operand(top_cube + 64'd1, 1'b0);
        send_operand(64'h8000_0000_0000_0000, 1'b0);
        send_operand(64'h7FFF_FFFF_FFFF_FFFF, 1'b1);
        send_operand(64'h5555_5555_5555_5555, 1'b0);
        send_operand(64'hAAAA_AAAA_AAAA_AAAA, 1'b1);
        drain_results();
    endtask

    task automatic test_random();
        int blk;
        int n;
        for (blk = 0; blk < RANDOM_ITEMS / BLOCK_ITEMS; blk++) begin
            send_gap_max = ($urandom_range(0, 3) == 0) ? 0 : MAX_GAP;
            take_gap_max = ($urandom_range(0, 3) == 0) ? 0 : MAX_GAP;
            for (n = 0; n < BLOCK_ITEMS; n++) begin
                send_operand(draw_magnitude(), 1'($urandom_range(0, 1)));
            end
        end
        drain_results();
    endtask

    // output held off long enough for the chain to fill and stall its input
    task automatic test_output_stall();
        int n;
        send_gap_max = 0;
        take_gap_max = MAX_GAP;
        hold_request = 1'b1;
        for (n = 0; n < 80; n++) begin
            send_operand(draw_magnitude(), 1'($urandom_range(0, 1)));
        end
        drain_results();
    endtask

    // sender pauses until the chain is empty, then restarts
    task automatic test_drain_pause();
        int burst;
        int n;
        send_gap_max = MAX_GAP;
        take_gap_max = MAX_GAP;
        for (burst = 0; burst < 3; burst++) begin
            for (n = 0; n < 30; n++) begin
                send_operand(draw_magnitude(), 1'($urandom_range(0, 1)));
            end
            drain_results();
        end
    endtask

    initial begin : result_sink
        int stall;
        forever begin
            stall = $urandom_range(0, take_gap_max);
            if (hold_request) begin
                stall        = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (stall > 0) begin
                out_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_if.ready <= 1'b1;
            do @(posedge i_clk); while (!(i_rst_n && out_if.valid));
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (expected_roots.size() == 0) begin
                $error("unexpected result transfer: root %0d", out_if.root);
                failures++;
            end else begin
                oldest_root = expected_roots.pop_front();
                if (out_if.root !== oldest_root.root) begin
                    $error("root: expected %0d, got %0d", oldest_root.root, out_if.root);
                    failures++;
                end
                if (out_if.root_negative !== oldest_root.root_negative) begin
                    $error("root_negative: expected %0b, got %0b",
                           oldest_root.root_negative, out_if.root_negative);
                    failures++;
                end
                if (out_if.inexact !== oldest_root.inexact) begin
                    $error("inexact: expected %0b, got %0b",
                           oldest_root.inexact, out_if.inexact);
                    failures++;
                end
            end
        end
    end

    initial begin
        i_rst_n         <= 1'b0;
        in_if.valid     <= 1'b0;
        in_if.magnitude <= '0;
        in_if.negative  <= 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_random();
        test_output_stall();
        test_drain_pause();

        repeat (2 * LATENCY) @(posedge i_clk);
        if (failures == 0 && expected_roots.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== integer_cube_root.f =====
hw/rtl/icr_pkg.sv
hw/rtl/icr_if.sv
hw/rtl/icr_cell.sv
hw/rtl/integer_cube_root.sv
dv/tb_top.sv
